// ===== design/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies; used by every design file by scoped names.
`default_nettype none
package sha256_pkg;

   localparam logic [1:0] CMD_RESTART = 2'd0;
   localparam logic [1:0] CMD_ABSORB  = 2'd1;
   localparam logic [1:0] CMD_FINISH  = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] msg_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [255:0] INITIAL_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

// ===== design/sha256_front.sv =====
// Front end: accepts transactions, drops unused commands, queues the rest.
// Depends on sha256_pkg.
`default_nettype none
module sha256_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire sha256_pkg::req_type req_data,
   output logic                     q_valid,
   input  wire logic                q_ready,
   output sha256_pkg::req_type      q_data
);
   localparam int AW = $clog2(sha256_pkg::QUEUE_DEPTH);

   sha256_pkg::req_type mem_ff [sha256_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic push, pop;

   // Command 3 is accepted and discarded.
   assign req_ready = (cnt_ff != (AW+1)'(sha256_pkg::QUEUE_DEPTH));
   assign push = req_valid && req_ready && (req_data.command != sha256_pkg::CMD_UNUSED);
   assign q_valid = (cnt_ff != '0);
   assign pop = q_valid && q_ready;
   assign q_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + AW'(1) : wr_ff;
      rd_in = pop ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= req_data;
      end
   end
endmodule
`default_nettype wire

// ===== design/sha256_back.sv =====
// Back end: block buffer, padding, 64-round compression and digest output.
// Depends on sha256_pkg.
`default_nettype none
module sha256_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   output logic                     q_ready,
   input  wire sha256_pkg::req_type q_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output sha256_pkg::rsp_type      rsp_data
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_RND  = 3'd3;
   localparam logic [2:0] ST_ADD  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]   state_ff, state_in;
   logic [255:0] hash_ff, hash_in;
   logic [255:0] work_ff, work_in;
   logic [31:0]  win_ff [16];
   // The block buffer holds sixteen big-endian words, written a byte at a time.
   logic [31:0]  blk_ff [16];
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bits_ff, bits_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic [5:0]   pos_ff, pos_in;
   logic         final_ff, final_in;
   logic [2:0]   oidx_ff, oidx_in;
   logic         blk_we;
   logic [5:0]   blk_wa;
   logic [7:0]   blk_wd;
   logic         rnd_step;
   logic [31:0]  w_new, a, b, c, d, e, f, g, h, t1, t2, wsrc;
   logic [5:0]   widx;

   assign q_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data.digest_word = hash_ff[255 - 32*oidx_ff -: 32];
   assign rsp_data.word_index = oidx_ff;
   assign rsp_data.last_word = (oidx_ff == 3'd7);

   // One round of schedule expansion and compression.
   always_comb begin
      {a, b, c, d, e, f, g, h} = work_ff;
      widx = rnd_ff[5:0];
      wsrc = blk_ff[widx[3:0]];
      if (rnd_ff < 7'd16) begin
         w_new = wsrc;
      end else begin
         w_new = (sha256_pkg::rotr(win_ff[14], 17) ^ sha256_pkg::rotr(win_ff[14], 19)
                  ^ (win_ff[14] >> 10)) + win_ff[9]
               + (sha256_pkg::rotr(win_ff[1], 7) ^ sha256_pkg::rotr(win_ff[1], 18)
                  ^ (win_ff[1] >> 3)) + win_ff[0];
      end
      t1 = h + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11) ^ sha256_pkg::rotr(e, 25))
         + ((e & f) ^ (~e & g)) + sha256_pkg::ROUND_K[widx] + w_new;
      t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
         + ((a & b) ^ (a & c) ^ (b & c));
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      hash_in = hash_ff;
      work_in = work_ff;
      fill_in = fill_ff;
      bits_in = bits_ff;
      rnd_in = rnd_ff;
      pos_in = pos_ff;
      final_in = final_ff;
      oidx_in = oidx_ff;
      blk_we = 1'b0;
      blk_wa = fill_ff;
      blk_wd = q_data.msg_byte;
      rnd_step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_data.command)
                  sha256_pkg::CMD_RESTART: begin
                     hash_in = sha256_pkg::INITIAL_HASH;
                     fill_in = '0;
                     bits_in = '0;
                  end
                  sha256_pkg::CMD_ABSORB: begin
                     blk_we = 1'b1;
                     fill_in = fill_ff + 6'd1;
                     if (fill_ff == 6'd63) begin
                        final_in = 1'b0;
                        state_in = ST_LOAD;
                     end
                  end
                  sha256_pkg::CMD_FINISH: begin
                     blk_we = 1'b1;
                     blk_wd = 8'h80;
                     bits_in = bits_ff + {55'd0, fill_ff, 3'd0};
                     pos_in = fill_ff + 6'd1;
                     final_in = 1'b1;
                     if (fill_ff == 6'd63) begin
                        // The marker byte completes the block, so it is compressed at once.
                        state_in = ST_LOAD;
                     end else begin
                        state_in = ST_PAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // One padding byte per cycle up to the end of the block; the length
         // goes in the last eight unless this is the first block of a short tail.
         ST_PAD: begin
            blk_we = 1'b1;
            blk_wa = pos_ff;
            if (fill_ff > 6'd55 && final_ff) begin
               blk_wd = 8'h00;
            end else if (pos_ff >= 6'd56) begin
               blk_wd = bits_ff[63 - 8*(pos_ff - 6'd56) -: 8];
            end else begin
               blk_wd = 8'h00;
            end
            if (pos_ff == 6'd63) begin
               state_in = ST_LOAD;
            end
            pos_in = pos_ff + 6'd1;
         end
         ST_LOAD: begin
            work_in = hash_ff;
            rnd_in = '0;
            state_in = ST_RND;
         end
         ST_RND: begin
            rnd_step = 1'b1;
            work_in = {t1 + t2, a, b, c, d + t1, e, f, g};
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[32*i +: 32] = hash_ff[32*i +: 32] + work_ff[32*i +: 32];
            end
            if (!final_ff) begin
               bits_in = bits_ff + 64'd512;
               state_in = ST_IDLE;
            end else if (fill_ff > 6'd55) begin
               // Short tail: the length goes into an extra block.
               fill_in = '0;
               pos_in = '0;
               state_in = ST_PAD;
            end else begin
               oidx_in = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  hash_in = sha256_pkg::INITIAL_HASH;
                  fill_in = '0;
                  bits_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hash_ff <= sha256_pkg::INITIAL_HASH;
         fill_ff <= '0;
         bits_ff <= '0;
         final_ff <= 1'b0;
         oidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff <= hash_in;
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         final_ff <= final_in;
         oidx_ff <= oidx_in;
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rnd_ff <= rnd_in;
      pos_ff <= pos_in;
      if (blk_we) begin
         blk_ff[blk_wa[5:2]][31 - 8*blk_wa[1:0] -: 8] <= blk_wd;
      end
      if (rnd_step) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[15] <= w_new;
      end
   end
endmodule
`default_nettype wire

// ===== design/sha256_stream_hasher_core.sv =====
// SHA-256 stream hasher top level: front queue and compression back end.
// An absorb is registered in the front queue before the back end can take it;
// a block compression (load, rounds, add) keeps the back end busy after byte 64.
// Finish: padding to the end of the block, one or two compressions, then 8 words.
// The back end takes no new bytes while it compresses, at one round per cycle.
// Reset loads the initial hash words and clears counters and the queue.
`default_nettype none
module sha256_stream_hasher_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire sha256_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output sha256_pkg::rsp_type      rsp_data
);
   logic q_valid, q_ready;
   sha256_pkg::req_type q_data;

   sha256_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
   );

   sha256_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

// ===== design/sha256_checker.sv =====
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_pkg and sha256_stream_hasher_core.
`default_nettype none
module sha256_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire sha256_pkg::rsp_type rsp_data
);
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == 3'd7)))
      else $error("last_word mismatch");
   a_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.word_index != 3'd7) |=>
      (rsp_valid && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
      else $error("digest words out of order");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while stalled");
endmodule

bind sha256_stream_hasher_core sha256_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
`default_nettype wire

// ===== test/sha256_stream_hasher_core_tb.sv =====
// Testbench for sha256_stream_hasher_core: directed and random byte streams,
// checked against a SHA-256 digest predictor kept inside this file.
// Depends on sha256_pkg for the command codes and the packed transaction types.
module sha256_stream_hasher_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD = 400;

   localparam logic [31:0] K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };
   localparam logic [31:0] IV_TABLE [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   sha256_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   sha256_pkg::rsp_type rsp_data;

   // Predictor state of the hasher.
   logic [31:0]         chain_words [8];
   logic [7:0]          buffered_bytes [64];
   logic [5:0]          byte_count;
   logic [63:0]         compressed_bits;
   sha256_pkg::rsp_type pending_words [$];

   int  mismatch_count = 0;
   int  idle_cycles = 0;
   int  items_sent = 0;
   bit  sender_bursts = 1'b1;
   bit  receiver_bursts = 1'b1;
   int  receiver_hold = 0;
   int  hold_requests = 0;
   int  hold_served = 0;

   sha256_stream_hasher_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // One 64-round compression of the buffered block into the chaining words.
   function automatic void compress_buffer();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            w[t] = {buffered_bytes[4*t], buffered_bytes[4*t+1],
                    buffered_bytes[4*t+2], buffered_bytes[4*t+3]};
         end else begin
            w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
         end
      end
      {a, b, c, d, e, f, g, h} = {chain_words[0], chain_words[1], chain_words[2],
         chain_words[3], chain_words[4], chain_words[5], chain_words[6], chain_words[7]};
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + K_TABLE[t] + w[t];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_words[0] += a; chain_words[1] += b; chain_words[2] += c; chain_words[3] += d;
      chain_words[4] += e; chain_words[5] += f; chain_words[6] += g; chain_words[7] += h;
   endfunction

   function automatic void start_message();
      for (int i = 0; i < 8; i++) chain_words[i] = IV_TABLE[i];
      byte_count = '0;
      compressed_bits = '0;
   endfunction

   // Advance the predictor by one accepted transaction.
   function automatic void predict_digest(sha256_pkg::req_type item);
      int                  pos;
      sha256_pkg::rsp_type word;
      case (item.command)
         sha256_pkg::CMD_RESTART: begin
            start_message();
         end
         sha256_pkg::CMD_ABSORB: begin
            buffered_bytes[byte_count] = item.msg_byte;
            byte_count++;
            if (byte_count == 0) begin
               compress_buffer();
               compressed_bits += 64'd512;
            end
         end
         sha256_pkg::CMD_FINISH: begin
            pos = byte_count;
            compressed_bits += 64'(pos) * 8;
            buffered_bytes[pos] = 8'h80;
            pos++;
            if (pos > 56) begin
               while (pos < 64) begin
                  buffered_bytes[pos] = 8'h00;
                  pos++;
               end
               compress_buffer();
               pos = 0;
            end
            while (pos < 56) begin
               buffered_bytes[pos] = 8'h00;
               pos++;
            end
            for (int i = 0; i < 8; i++)
               buffered_bytes[56+i] = compressed_bits[63-8*i -: 8];
            compress_buffer();
            for (int i = 0; i < 8; i++) begin
               word.digest_word = chain_words[i];
               word.word_index = 3'(i);
               word.last_word = (i == 7);
               pending_words.push_back(word);
            end
            start_message();
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      mismatch_count++;
   endtask

   // Send one transaction, with an optional random gap in front of it.
   task automatic send_item(logic [1:0] command, logic [7:0] value);
      sha256_pkg::req_type item;
      if (sender_bursts && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      item.command = command;
      item.msg_byte = value;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      predict_digest(item);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   task automatic send_message(int length);
      for (int i = 0; i < length; i++) send_item(sha256_pkg::CMD_ABSORB, 8'($urandom));
      send_item(sha256_pkg::CMD_FINISH, 8'($urandom));
   endtask

   task automatic wait_drained();
      drop_valid();
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stall bursts and long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         receiver_hold <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (receiver_hold > 0) begin
         receiver_hold <= receiver_hold - 1;
         rsp_ready <= 1'b0;
      end else if (receiver_bursts && $urandom_range(0, 7) == 0) begin
         receiver_hold <= $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result checker against the oldest expected digest word.
   always @(posedge clock) begin
      sha256_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected digest word", rsp_data.digest_word, 32'h0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_data.digest_word !== want.digest_word)
               report_mismatch("digest_word", rsp_data.digest_word, want.digest_word);
            if (rsp_data.word_index !== want.word_index)
               report_mismatch("word_index", 32'(rsp_data.word_index), 32'(want.word_index));
            if (rsp_data.last_word !== want.last_word)
               report_mismatch("last_word", 32'(rsp_data.last_word), 32'(want.last_word));
         end
      end
   end

   // Watchdog on cycles with no accepted transaction.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Empty message, short messages and every command.
   task automatic test_directed();
      send_item(sha256_pkg::CMD_FINISH, 8'h00);
      send_item(sha256_pkg::CMD_ABSORB, 8'h00);
      send_item(sha256_pkg::CMD_ABSORB, 8'hff);
      send_item(sha256_pkg::CMD_UNUSED, 8'hff);
      send_item(sha256_pkg::CMD_FINISH, 8'hff);
      send_item(sha256_pkg::CMD_ABSORB, 8'h5a);
      send_item(sha256_pkg::CMD_RESTART, 8'ha5);
      send_item(sha256_pkg::CMD_ABSORB, 8'h61);
      send_item(sha256_pkg::CMD_ABSORB, 8'h62);
      send_item(sha256_pkg::CMD_ABSORB, 8'h63);
      send_item(sha256_pkg::CMD_FINISH, 8'h00);
      wait_drained();
   endtask

   // Padding boundaries: a full block then 63 bytes, and a 56-byte short tail.
   task automatic test_block_boundaries();
      send_message(127);
      send_message(56);
      wait_drained();
   endtask

   // Random messages mixed with restarts, unused commands and aborted messages.
   task automatic test_random_messages();
      int first;
      int choice;
      first = items_sent;
      while (items_sent - first < 20) begin
         choice = $urandom_range(0, 9);
         if (choice < 7) begin
            send_message($urandom_range(0, 5));
         end else if (choice == 7) begin
            send_item(sha256_pkg::CMD_ABSORB, 8'($urandom));
            send_item(sha256_pkg::CMD_RESTART, 8'($urandom));
         end else begin
            send_item(sha256_pkg::CMD_UNUSED, 8'($urandom));
         end
      end
      wait_drained();
   endtask

   // Long receiver hold-off while further messages queue up behind it.
   task automatic test_output_backpressure();
      hold_requests++;
      for (int i = 0; i < 4; i++) send_message($urandom_range(0, 3));
      wait_drained();
   endtask

   // Final part without any idling on either side.
   task automatic test_full_rate();
      sender_bursts = 1'b0;
      receiver_bursts = 1'b0;
      for (int i = 0; i < 3; i++) send_message($urandom_range(0, 4));
      wait_drained();
   endtask

   initial begin
      start_message();
      for (int i = 0; i < 64; i++) buffered_bytes[i] = 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_block_boundaries();
      test_random_messages();
      test_output_backpressure();
      test_full_rate();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && pending_words.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
